### hdl/eapm_pkg.sv
// Shared types and constants for the exact attribute pair matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package eapm_pkg;

  // Field widths fixed by the word formats
  localparam int ROW_INDEX_W = 6;
  localparam int ROW_CNT_W   = 7;
  localparam int GROUP_W     = 8;
  localparam int CODE_W      = 16;
  localparam int ATTR_CNT_W  = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  // Default sizes
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_ATTRS  = 4;
  localparam int DEF_ATTR_WIDTH = 16;

  // Compare lanes; row j lives in bank j mod LANES
  localparam int LANES     = 4;
  localparam int LANE_BITS = 2;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_ATTRS_IN_USE = 2'd1,
    REG_INDEX_BASE   = 2'd2
  } cfg_reg_t;

  // Input function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [ROW_INDEX_W-1:0]    row_index;
    logic signed [GROUP_W-1:0] group;
    logic [CODE_W-1:0]         attr_a;
    logic [CODE_W-1:0]         attr_b;
    logic [CODE_W-1:0]         attr_c;
    logic [CODE_W-1:0]         attr_d;
  } in_word_t;

  typedef struct packed {
    logic [ROW_CNT_W-1:0] match_index;
    logic                 found;
    logic                 last;
  } out_word_t;

  // Sequencer to merge stage
  typedef struct packed {
    logic                 load;    // take a new hit mask
    logic [LANES-1:0]     mask;
    logic [ROW_CNT_W-1:0] base;    // row index of lane 0
    logic                 finish;  // flush the held match as the final word
  } merge_ctl_t;

  // Merge stage to sequencer
  typedef struct packed {
    logic drained;   // no hits left in the mask
    logic out_free;  // output register can take a word this cycle
  } merge_sts_t;

endpackage

### hdl/exact_attribute_pair_matcher.sv
// Exact attribute pair matcher, top level: config registers, sequencer, lanes, merge.
// A query fetches its own row first, then scans the banks in steps and ends with a final word:
// four lanes each compare one row of their bank per scan step, and the merge stage
// emits at most one word per cycle, so a step with several hits stays until they drain.
// One query is in work at a time. rst is synchronous and clears the sequencer, merge
// state and config registers (row_count 64, attrs_in_use 4, index_base 1); rows are not.
`timescale 1ns / 1ps

module exact_attribute_pair_matcher import eapm_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_ATTRS  = DEF_MAX_ATTRS,
  parameter int ATTR_WIDTH = DEF_ATTR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data
);

  localparam int ROW_W      = GROUP_W + MAX_ATTRS * ATTR_WIDTH;
  localparam int BANK_DEPTH = (MAX_ROWS + LANES - 1) / LANES;
  localparam int STEP_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_QROW   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [ROW_CNT_W-1:0]  row_count;
  logic [ATTR_CNT_W-1:0] attrs_in_use;
  logic                  index_base;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_CNT_W'(64);
      attrs_in_use <= ATTR_CNT_W'(4);
      index_base   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_ATTRS_IN_USE: attrs_in_use <= cfg_data[ATTR_CNT_W-1:0];
        REG_INDEX_BASE:   index_base   <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Saturated counts
  logic [ROW_CNT_W-1:0]  rc_sat;
  logic [ATTR_CNT_W-1:0] na_sat;
  logic [ROW_CNT_W-1:0]  rc_m1;
  logic [STEP_W-1:0]     last_step;

  always_comb begin
    rc_sat = (row_count > ROW_CNT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS) : row_count;
    if (attrs_in_use == '0) begin
      na_sat = ATTR_CNT_W'(1);
    end else if (attrs_in_use > ATTR_CNT_W'(MAX_ATTRS)) begin
      na_sat = ATTR_CNT_W'(MAX_ATTRS);
    end else begin
      na_sat = attrs_in_use;
    end
  end

  assign rc_m1     = rc_sat - ROW_CNT_W'(1);
  assign last_step = STEP_W'(rc_m1 >> LANE_BITS);

  // Input word decode
  logic                 in_acc;
  logic                 in_row_ok;
  logic [STEP_W-1:0]    in_step;
  logic [ROW_W-1:0]     wr_row;
  logic [CODE_W-1:0]    attr_in [4];

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_row_ok = {1'b0, in_data.row_index} < ROW_CNT_W'(MAX_ROWS);
  assign in_step   = STEP_W'(in_data.row_index >> LANE_BITS);

  always_comb begin
    attr_in[0] = in_data.attr_a;
    attr_in[1] = in_data.attr_b;
    attr_in[2] = in_data.attr_c;
    attr_in[3] = in_data.attr_d;
    wr_row = '0;
    wr_row[ROW_W-1 -: GROUP_W] = in_data.group;
    for (int k = 0; k < MAX_ATTRS; k++) begin
      wr_row[k*ATTR_WIDTH +: ATTR_WIDTH] = attr_in[k][ATTR_WIDTH-1:0];
    end
  end

  // Sequencer registers
  logic [ROW_INDEX_W-1:0] q_index;
  logic [ROW_W-1:0]       q_row;
  logic [STEP_W-1:0]      step;
  logic                   rd_en;
  logic [STEP_W-1:0]      rd_addr;
  logic [ROW_W-1:0]       lane_row [LANES];
  logic [LANES-1:0]       lane_hit;
  merge_ctl_t             mctl;
  merge_sts_t             msts;

  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    rd_addr     = '0;
    mctl.load   = 1'b0;
    mctl.mask   = lane_hit;
    mctl.base   = ROW_CNT_W'(step) << LANE_BITS;
    mctl.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.func == FUNC_QUERY)) begin
          if (in_row_ok) begin
            rd_en      = 1'b1;
            rd_addr    = in_step;
            state_next = ST_QROW;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_QROW: begin
        if (rc_sat != '0) begin
          rd_en      = 1'b1;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        mctl.load  = 1'b1;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (msts.drained) begin
          if (step == last_step) begin
            state_next = ST_FINISH;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = step + STEP_W'(1);
            state_next = ST_SCAN;
          end
        end
      end
      ST_FINISH: begin
        if (msts.out_free) begin
          mctl.finish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_index <= in_data.row_index;
    end
    if (state == ST_QROW) begin
      q_row <= lane_row[q_index[LANE_BITS-1:0]];
    end
    if (rd_en) begin
      step <= rd_addr;
    end
  end

  // Lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic lane_wr;
    assign lane_wr = in_acc && (in_data.func == FUNC_LOAD) && in_row_ok &&
                     (in_data.row_index[LANE_BITS-1:0] == LANE_BITS'(l));
    eapm_lane #(
      .MAX_ATTRS  (MAX_ATTRS),
      .ATTR_WIDTH (ATTR_WIDTH),
      .BANK_DEPTH (BANK_DEPTH),
      .STEP_W     (STEP_W),
      .LANE_ID    (l)
    ) u_lane (
      .clk     (clk),
      .wr_en   (lane_wr),
      .wr_addr (in_step),
      .wr_row  (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_row  (lane_row[l]),
      .step    (step),
      .q_row   (q_row),
      .q_index (q_index),
      .rc      (rc_sat),
      .na      (na_sat),
      .hit     (lane_hit[l])
    );
  end

  // Merge
  eapm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mctl),
    .sts        (msts),
    .index_base (index_base),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### hdl/eapm_lane.sv
// One compare lane: a bank of rows (every LANES-th row) and its comparator.
// Depends on eapm_pkg.
`timescale 1ns / 1ps

module eapm_lane import eapm_pkg::*; #(
  parameter int MAX_ATTRS  = DEF_MAX_ATTRS,
  parameter int ATTR_WIDTH = DEF_ATTR_WIDTH,
  parameter int BANK_DEPTH = 16,
  parameter int STEP_W     = 4,
  parameter int LANE_ID    = 0,
  localparam int ROW_W     = GROUP_W + MAX_ATTRS * ATTR_WIDTH
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [STEP_W-1:0]      wr_addr,
  input  logic [ROW_W-1:0]       wr_row,
  input  logic                   rd_en,
  input  logic [STEP_W-1:0]      rd_addr,
  output logic [ROW_W-1:0]       rd_row,
  input  logic [STEP_W-1:0]      step,
  input  logic [ROW_W-1:0]       q_row,
  input  logic [ROW_INDEX_W-1:0] q_index,
  input  logic [ROW_CNT_W-1:0]   rc,
  input  logic [ATTR_CNT_W-1:0]  na,
  output logic                   hit
);

  logic [ROW_W-1:0] bank [BANK_DEPTH];

  // Row bank, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= bank[rd_addr];
    end
  end

  logic [ROW_CNT_W-1:0] row_j;
  logic [GROUP_W-1:0]   q_group;
  logic [GROUP_W-1:0]   j_group;
  logic                 group_block;
  logic                 mismatch;

  assign row_j   = (ROW_CNT_W'(step) << LANE_BITS) + ROW_CNT_W'(LANE_ID);
  assign q_group = q_row[ROW_W-1 -: GROUP_W];
  assign j_group = rd_row[ROW_W-1 -: GROUP_W];

  // Same non-negative group excludes the pair
  assign group_block = !q_group[GROUP_W-1] && (q_group == j_group);

  // Compare the attribute codes in use
  always_comb begin
    mismatch = 1'b0;
    for (int k = 0; k < MAX_ATTRS; k++) begin
      if ((ATTR_CNT_W'(k) < na) &&
          (q_row[k*ATTR_WIDTH +: ATTR_WIDTH] != rd_row[k*ATTR_WIDTH +: ATTR_WIDTH])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign hit = (row_j < rc) && (row_j != {1'b0, q_index}) && !group_block && !mismatch;

endmodule

### hdl/eapm_merge.sv
// Merge stage: turns lane hit masks into result words in ascending row order.
// Holds one match back so the final word of a query carries last.
// Depends on eapm_pkg.
`timescale 1ns / 1ps

module eapm_merge import eapm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  merge_ctl_t ctl,
  output merge_sts_t sts,
  input  logic       index_base,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  logic [LANES-1:0]     mask;
  logic [ROW_CNT_W-1:0] base;
  logic                 pend_valid;
  logic [ROW_CNT_W-1:0] pend_idx;

  logic [LANE_BITS-1:0] pos;
  logic                 out_free;
  logic                 push_ok;
  logic                 take_hit;

  // Lowest pending hit
  always_comb begin
    pos = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (mask[l]) begin
        pos = LANE_BITS'(l);
      end
    end
  end

  assign out_free     = !out_valid || out_ready;
  assign push_ok      = !pend_valid || out_free;
  assign take_hit     = !ctl.load && (mask != '0) && push_ok;
  assign sts.drained  = (mask == '0);
  assign sts.out_free = out_free;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.load) begin
        mask <= ctl.mask;
      end else if (take_hit) begin
        mask[pos] <= 1'b0;
      end
      if (ctl.finish) begin
        pend_valid <= 1'b0;
      end else if (take_hit) begin
        pend_valid <= 1'b1;
      end
      if (ctl.finish || (take_hit && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      base <= ctl.base;
    end else if ((mask != '0) && push_ok) begin
      pend_idx <= base + ROW_CNT_W'(pos);
      if (pend_valid) begin
        out_data.match_index <= pend_idx + ROW_CNT_W'(index_base);
        out_data.found       <= 1'b1;
        out_data.last        <= 1'b0;
      end
    end
    if (ctl.finish) begin
      out_data.match_index <= pend_valid ? pend_idx + ROW_CNT_W'(index_base) : '0;
      out_data.found       <= pend_valid;
      out_data.last        <= 1'b1;
    end
  end

endmodule
